// ----- rtl/label_majority_filter_3x3_unit_macros.svh -----
// assertion macros shared by the rtl files of the label majority filter
`ifndef LABEL_MAJORITY_FILTER_3X3_UNIT_MACROS_SVH
`define LABEL_MAJORITY_FILTER_3X3_UNIT_MACROS_SVH

// property that must hold in the same cycle as its antecedent
`define LMF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its antecedent
`define LMF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lmf_pkg.sv -----
// shared types and constants of the label majority filter
package lmf_pkg;

  localparam int LABEL_BITS    = 16;
  localparam int MAX_WIDTH     = 2048;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS    = 12;
  localparam int HEIGHT_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int WIN_SIZE      = 9;
  localparam int MAJORITY_MIN  = 5;
  localparam int MIN_DIM       = 3;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  typedef logic [LABEL_BITS-1:0]  label_t;
  typedef logic [COL_BITS-1:0]    col_t;
  typedef logic [HEIGHT_BITS-1:0] row_t;

  // what the window stage needs to know about one item
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
    col_t qc;
  } stage_ctl_t;

  // decode of the beat at the input port
  typedef struct packed {
    logic       keep;
    logic       in_frame;
    col_t       col;
    stage_ctl_t ctl;
  } item_ctl_t;

endpackage

// ----- rtl/lmf_vote.sv -----
// nine-way majority vote over a 3x3 label window
module lmf_vote import lmf_pkg::*; (
  input  label_t win [WIN_SIZE],
  output logic   found,
  output label_t majority
);

  always_comb begin
    logic [WIN_SIZE-1:0] eq;
    found    = 1'b0;
    majority = '0;
    for (int a = 0; a < WIN_SIZE; a++) begin
      for (int b = 0; b < WIN_SIZE; b++) begin
        eq[b] = (win[b] == win[a]);
      end
      // at most one label can pass, so or-ing the winners is safe
      if ($countones(eq) > MAJORITY_MIN) begin
        found    = 1'b1;
        majority = majority | win[a];
      end
    end
  end

endmodule

// ----- rtl/lmf_ctrl.sv -----
// configuration registers and input / output position counters
`include "label_majority_filter_3x3_unit_macros.svh"

module lmf_ctrl import lmf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     take,
  input  logic                     func,
  output item_ctl_t                item,
  output logic                     restart
);

  logic [WIDTH_BITS-1:0]  image_width, width_cfg, w_last;
  logic [HEIGHT_BITS-1:0] image_height, height_cfg, h_last;
  col_t column_count, column_count_next, out_col, out_col_next;
  row_t row_count, row_count_next, out_row, out_row_next;
  logic col_wrap, out_col_wrap, in_frame, emit, interior, last, load;

  always_comb begin
    width_cfg = cfg_data[WIDTH_BITS-1:0];
    if (width_cfg < WIDTH_BITS'(MIN_DIM)) begin
      width_cfg = WIDTH_BITS'(MIN_DIM);
    end else if (width_cfg > WIDTH_BITS'(MAX_WIDTH)) begin
      width_cfg = WIDTH_BITS'(MAX_WIDTH);
    end
    height_cfg = cfg_data[HEIGHT_BITS-1:0];
    if (height_cfg < HEIGHT_BITS'(MIN_DIM)) begin
      height_cfg = HEIGHT_BITS'(MIN_DIM);
    end
  end

  always_comb begin
    unique case (cfg_index) inside
      CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: restart = cfg_write;
      default:                           restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_BITS'(RESET_WIDTH);
      image_height <= HEIGHT_BITS'(RESET_HEIGHT);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= width_cfg;
        CFG_IMAGE_HEIGHT: image_height <= height_cfg;
        default: ;
      endcase
    end
  end

  assign w_last   = image_width - 1'b1;
  assign h_last   = image_height - 1'b1;
  assign in_frame = (row_count < image_height);
  // one row plus one pixel must be in before the first result
  assign emit     = (row_count > row_t'(1)) || ((row_count == row_t'(1)) && (column_count != '0));
  assign interior = (out_row != '0) && (out_row < h_last) &&
                    (out_col != '0) && ({1'b0, out_col} < w_last);
  assign last     = (out_row == h_last) && ({1'b0, out_col} == w_last);

  assign item.keep         = !(in_frame && func);
  assign item.in_frame     = in_frame;
  assign item.col          = column_count;
  assign item.ctl.emit     = emit;
  assign item.ctl.interior = interior;
  assign item.ctl.last     = last;
  assign item.ctl.qc       = out_col;

  assign load = take && item.keep;

  always_comb begin
    col_wrap          = ({1'b0, column_count} == w_last);
    column_count_next = col_wrap ? '0 : column_count + 1'b1;
    row_count_next    = col_wrap ? row_count + 1'b1 : row_count;
    out_col_wrap      = ({1'b0, out_col} == w_last);
    out_col_next      = out_col;
    out_row_next      = out_row;
    if (emit) begin
      out_col_next = out_col_wrap ? '0 : out_col + 1'b1;
      out_row_next = out_col_wrap ? out_row + 1'b1 : out_row;
    end
    // the last result of a frame starts the next one
    if (emit && last) begin
      column_count_next = '0;
      row_count_next    = '0;
      out_col_next      = '0;
      out_row_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      row_count    <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (load) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      out_col      <= out_col_next;
      out_row      <= out_row_next;
    end
  end

  `LMF_ASSERT_NOW(a_col_in_range, 1'b1, ({1'b0, column_count} < image_width), "input column out of range")
  `LMF_ASSERT_NOW(a_out_in_range, 1'b1, (({1'b0, out_col} < image_width) && (out_row < image_height)), "output position out of range")
  `LMF_ASSERT_NEXT(a_restart_clears, restart, ((column_count == '0) && (row_count == '0) && (out_col == '0) && (out_row == '0)), "config write did not restart frame")

endmodule

// ----- rtl/lmf_window.sv -----
// line stores, 3x3 window registers and the in-place majority update
module lmf_window import lmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       load,
  input  col_t       col,
  input  label_t     lab,
  input  logic       advance,
  input  stage_ctl_t ctl,
  output label_t     result
);

  label_t decided_line [MAX_WIDTH];
  label_t raw_line [MAX_WIDTH];
  label_t decided_rd, raw_rd, lab_s1;
  label_t window_regs [WIN_SIZE];
  label_t shifted [WIN_SIZE];
  label_t window_next [WIN_SIZE];
  label_t majority;
  logic   found;

  // read before write on the raw line: the old row comes out
  always_ff @(posedge clk) begin
    if (load) begin
      raw_line[col] <= lab;
      raw_rd        <= raw_line[col];
      decided_rd    <= decided_line[col];
      lab_s1        <= lab;
    end
    if (advance && ctl.emit) begin
      decided_line[ctl.qc] <= result;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r*3]     = window_regs[r*3 + 1];
      shifted[r*3 + 1] = window_regs[r*3 + 2];
    end
    shifted[2] = decided_rd;
    shifted[5] = raw_rd;
    shifted[8] = lab_s1;
  end

  lmf_vote u_vote (
    .win      (shifted),
    .found    (found),
    .majority (majority)
  );

  // border pixels keep the centre
  assign result = (ctl.interior && found) ? majority : shifted[4];

  always_comb begin
    for (int k = 0; k < WIN_SIZE; k++) begin
      window_next[k] = shifted[k];
    end
    // the decided centre becomes the left neighbour of the next pixel
    if (ctl.emit) begin
      window_next[4] = result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int k = 0; k < WIN_SIZE; k++) begin
        window_regs[k] <= '0;
      end
    end else if (advance) begin
      for (int k = 0; k < WIN_SIZE; k++) begin
        window_regs[k] <= window_next[k];
      end
    end
  end

endmodule

// ----- rtl/label_majority_filter_3x3_unit.sv -----
// top level of the streaming 3x3 label majority filter
// Usage:
//   Input channel (in_valid / in_stall, label, func) takes one label per beat in
//   raster order; func high marks a drain beat. Drain beats before the frame's
//   last pixel are taken and dropped; after it, W+1 beats (drain or pixel) flush
//   the rest of the frame, pixel labels in that tail being discarded.
//   Output channel (out_valid / out_stall, out_label, frame_last) gives one final
//   label per beat in raster order, frame_last high on pixel W*H-1.
//   Each result belongs to the pixel W+1 input beats earlier; from its causing
//   beat it is registered in the window stage, then in the output register.
//   Throughput is one beat per cycle unless the output stalls: the line stores
//   are read once per beat and the window's nine-way vote is combinational.
//   When the receiver stalls, the output register holds its beat and the window
//   stage holds one more; the input then stalls until the output moves.
//   Configuration (cfg_write, cfg_index, cfg_data) writes image_width (index 0)
//   or image_height (index 1) and restarts the frame; the user writes only while
//   idle, unchecked by the block. Reset sets width 640 and height 480 and clears
//   counters and window; line stores need no clearing, being written before use.
`include "label_majority_filter_3x3_unit_macros.svh"

module label_majority_filter_3x3_unit import lmf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  label_t                   label,
  input  logic                     func,
  output logic                     out_valid,
  input  logic                     out_stall,
  output label_t                   out_label,
  output logic                     frame_last,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  item_ctl_t  item;
  stage_ctl_t s1_ctl;
  label_t     lab_in, result;
  logic       restart, take, load, advance, s1_valid;

  // the window stage moves unless its result would land on a stalled output
  assign advance  = s1_valid && (!s1_ctl.emit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;
  assign load     = take && item.keep;
  assign lab_in   = item.in_frame ? label : '0;

  lmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .func      (func),
    .item      (item),
    .restart   (restart)
  );

  lmf_window u_window (
    .clk     (clk),
    .rst     (rst),
    .clear   (restart),
    .load    (load),
    .col     (item.col),
    .lab     (lab_in),
    .advance (advance),
    .ctl     (s1_ctl),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance && s1_ctl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl <= item.ctl;
    end
    if (advance && s1_ctl.emit) begin
      out_label  <= result;
      frame_last <= s1_ctl.last;
    end
  end

  `LMF_ASSERT_NEXT(a_load_fills_stage, load, s1_valid, "accepted pixel did not reach window stage")
  `LMF_ASSERT_NEXT(a_blocked_stage_holds,
                   (s1_valid && s1_ctl.emit && out_valid && out_stall),
                   (s1_valid && s1_ctl.emit), "window stage dropped a blocked result")
  `LMF_ASSERT_NEXT(a_stalled_out_holds, (out_valid && out_stall),
                   (out_valid && $stable(out_label) && $stable(frame_last)),
                   "stalled result beat changed")

endmodule

// ----- verif/label_majority_filter_3x3_unit_tb.sv -----
// testbench of the 3x3 label majority filter: directed frames, then random frame streams
module label_majority_filter_3x3_unit_tb;
  import lmf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 470;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // indexes past the register list, the block ignores writes to them
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

  localparam label_t LBL_LO = 16'h0000;
  localparam label_t LBL_HI = 16'hFFFF;
  localparam label_t LBL_A  = 16'h0001;
  localparam label_t LBL_B  = 16'h8000;

  typedef struct packed {
    label_t lbl;
    logic   last;
  } out_beat_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;
  typedef enum int {MIX_BIASED, MIX_THREE, MIX_RANDOM, MIX_EXTREME} mix_t;

  typedef struct packed {
    row_kind_t                kind;
    label_t                   lbl;
    logic                     fn;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic                     typed_ok;
    out_beat_t                typed;
  } plan_row_t;

  localparam out_beat_t NO_RES = '{LBL_LO, 1'b0};

  // two 3x3 frames: a lone dissenting centre that gets outvoted, then a 5 to 4 split
  // that is not enough to flip the centre
  localparam plan_row_t PLAN [30] = '{
    '{ROW_REG,  LBL_LO,   FUNC_PIXEL, CFG_IMAGE_WIDTH,  16'h0000, 1'b0, NO_RES},
    '{ROW_REG,  LBL_LO,   FUNC_PIXEL, CFG_IMAGE_HEIGHT, 16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, 16'h5A5A, FUNC_DRAIN, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_HI,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_HI,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_HI,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_HI,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_LO,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b0}},
    '{ROW_BEAT, LBL_HI,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b0}},
    '{ROW_BEAT, LBL_HI,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b0}},
    '{ROW_BEAT, LBL_HI,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b0}},
    '{ROW_BEAT, LBL_HI,   FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b0}},
    '{ROW_BEAT, 16'hA5A5, FUNC_DRAIN, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b0}},
    '{ROW_BEAT, 16'h1234, FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b0}},
    '{ROW_BEAT, LBL_LO,   FUNC_DRAIN, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b0}},
    '{ROW_BEAT, LBL_HI,   FUNC_DRAIN, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_HI, 1'b1}},
    '{ROW_BEAT, LBL_A,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_A,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_A,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_A,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_B,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_A, 1'b0}},
    '{ROW_BEAT, LBL_B,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_A, 1'b0}},
    '{ROW_REG,  LBL_LO,   FUNC_PIXEL, CFG_SPARE_3,      16'hFFFF, 1'b0, NO_RES},
    '{ROW_BEAT, LBL_A,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_A, 1'b0}},
    '{ROW_BEAT, LBL_B,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_A, 1'b0}},
    '{ROW_BEAT, LBL_B,    FUNC_PIXEL, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_B, 1'b0}},
    '{ROW_BEAT, LBL_LO,   FUNC_DRAIN, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_B, 1'b0}},
    '{ROW_BEAT, LBL_LO,   FUNC_DRAIN, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_A, 1'b0}},
    '{ROW_BEAT, LBL_LO,   FUNC_DRAIN, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_B, 1'b0}},
    '{ROW_BEAT, LBL_LO,   FUNC_DRAIN, CFG_SPARE_2,      16'h0000, 1'b1, '{LBL_B, 1'b1}}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  label_t                   label = '0;
  logic                     func = FUNC_PIXEL;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  label_t                   out_label;
  logic                     frame_last;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  label_majority_filter_3x3_unit i_dut (
    .clk, .rst, .in_valid, .in_stall, .label, .func,
    .out_valid, .out_stall, .out_label, .frame_last,
    .cfg_write, .cfg_index, .cfg_data
  );

  // filter state as the predictor sees it
  logic [WIDTH_BITS-1:0]  width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  label_t                 decided_row [MAX_WIDTH];
  label_t                 raw_row [MAX_WIDTH];
  label_t                 win [WIN_SIZE];
  int unsigned            col_pos;
  int unsigned            row_pos;
  int unsigned            emit_pos;

  out_beat_t pending_labels [$];
  out_beat_t head_beat;

  int send_idle_pct = 13;
  int recv_idle_pct = 52;
  int cycle_cnt = 0;
  int fails = 0;
  int checked = 0;
  int beats_taken = 0;
  int frames_done = 0;
  int reg_writes = 0;

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_labels.size() == 0) begin
        $error("unexpected result beat: out_label %h frame_last %b", out_label, frame_last);
        fails++;
      end else begin
        head_beat = pending_labels.pop_front();
        checked++;
        if (out_label !== head_beat.lbl) begin
          $error("out_label: expected %h, actual %h", head_beat.lbl, out_label);
          fails++;
        end
        if (frame_last !== head_beat.last) begin
          $error("frame_last: expected %b, actual %b", head_beat.last, frame_last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
               pending_labels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = {20'd0, width_reg};
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = {16'd0, height_reg};
    if (h < MIN_DIM) h = MIN_DIM;
    return h;
  endfunction

  function automatic void clear_position();
    for (int k = 0; k < WIN_SIZE; k++) win[k] = '0;
    col_pos = 0;
    row_pos = 0;
    emit_pos = 0;
  endfunction

  function automatic bit in_tail();
    return (row_pos * eff_width() + col_pos) >= (eff_width() * eff_height());
  endfunction

  // one accepted beat through the in-place smoothing; returns 1 when it yields a result
  function automatic bit smooth_step(input label_t lbl, input logic fn, output bit taken,
                                     output out_beat_t res);
    int unsigned         w, h, total, pos, q, qr, qc;
    int                  hits;
    bit                  found;
    label_t              lab;
    label_t              vote;
    logic [COL_BITS-1:0] ci;
    logic [COL_BITS-1:0] qi;
    w = eff_width();
    h = eff_height();
    total = w * h;
    pos = row_pos * w + col_pos;
    res = '0;
    taken = 1'b1;
    if (pos < total && fn == FUNC_DRAIN) begin
      taken = 1'b0;
      return 1'b0;
    end
    lab = (pos < total) ? lbl : '0;
    ci = COL_BITS'(col_pos % MAX_WIDTH);
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = decided_row[ci];
    win[5] = raw_row[ci];
    win[8] = lab;
    raw_row[ci] = lab;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 32'hFFFF;
    end
    if (pos < w + 1) return 1'b0;
    q = emit_pos;
    qr = q / w;
    qc = q % w;
    vote = win[4];
    if (qr != 0 && qr + 1 < h && qc != 0 && qc + 1 < w) begin
      found = 1'b0;
      for (int a = 0; a < WIN_SIZE && !found; a++) begin
        hits = 0;
        for (int b = 0; b < WIN_SIZE; b++) if (win[b] == win[a]) hits++;
        if (hits > MAJORITY_MIN) begin
          vote = win[a];
          found = 1'b1;
        end
      end
    end
    qi = COL_BITS'(qc % MAX_WIDTH);
    decided_row[qi] = vote;
    win[4] = vote;
    res.lbl = vote;
    res.last = (q + 1 >= total);
    emit_pos++;
    // frame end restarts the position, the window carries over
    if (res.last) begin
      col_pos = 0;
      row_pos = 0;
      emit_pos = 0;
    end
    return 1'b1;
  endfunction

  task automatic send_beat(input label_t lbl, input logic fn, input logic typed_ok,
                           input out_beat_t typed);
    bit        taken;
    bit        got;
    out_beat_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    label <= lbl;
    func <= fn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = smooth_step(lbl, fn, taken, res);
    if (typed_ok) pending_labels.push_back(typed);
    else if (got) pending_labels.push_back(res);
    if (taken) beats_taken++;
  endtask

  // drop valid, let every expected beat come out, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = data[WIDTH_BITS-1:0];
      clear_position();
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = data[HEIGHT_BITS-1:0];
      clear_position();
    end
    reg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // mostly tiny frames; a few clamped and wider ones, upper width bits are don't-care
  task automatic reconfigure();
    int                       pick;
    int                       which;
    logic [CFG_DATA_BITS-1:0] d;
    which = $urandom_range(2);
    if (which != 1) begin
      pick = $urandom_range(99);
      if (pick < 70) d[11:0] = 12'($urandom_range(3, 8));
      else if (pick < 80) d[11:0] = 12'($urandom_range(0, 2));
      else if (pick < 90) d[11:0] = 12'($urandom_range(9, 40));
      else d[11:0] = 12'($urandom_range(3, 12));
      d[15:12] = 4'($urandom_range(15));
      write_reg(CFG_IMAGE_WIDTH, d);
    end
    if (which != 0) begin
      d = CFG_DATA_BITS'(($urandom_range(99) < 85) ? $urandom_range(3, 6)
                                                   : $urandom_range(0, 2));
      write_reg(CFG_IMAGE_HEIGHT, d);
    end
  endtask

  // one frame of pixels plus its flush; at pause_at the stream halts for a register
  // write that either restarts the frame or hits a spare index and changes nothing
  task automatic run_frame(input int pause_at, input bit abort);
    int unsigned n;
    bit          cut;
    mix_t        mix;
    label_t      pal [3];
    label_t      lbl;
    n = eff_width() * eff_height();
    cut = 1'b0;
    mix = mix_t'($urandom_range(3));
    for (int j = 0; j < 3; j++) pal[j] = label_t'($urandom);
    for (int i = 0; i < n && !cut; i++) begin
      if (i == pause_at) begin
        settle();
        if (abort) begin
          reconfigure();
          cut = 1'b1;
        end else begin
          write_reg(($urandom_range(1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                    CFG_DATA_BITS'($urandom));
        end
      end
      if (!cut) begin
        // stray drain inside the frame, dropped by the block
        if ($urandom_range(99) < 4) send_beat(label_t'($urandom), FUNC_DRAIN, 1'b0, NO_RES);
        case (mix)
          MIX_BIASED: lbl = ($urandom_range(99) < 80) ? pal[0] : pal[1];
          MIX_THREE:  lbl = pal[2'($urandom_range(2))];
          MIX_RANDOM: lbl = label_t'($urandom);
          default:    lbl = ($urandom_range(1) != 0) ? LBL_HI : LBL_LO;
        endcase
        send_beat(lbl, FUNC_PIXEL, 1'b0, NO_RES);
      end
    end
    if (!cut) begin
      while (in_tail()) begin
        send_beat(label_t'($urandom), ($urandom_range(99) < 85) ? FUNC_DRAIN : FUNC_PIXEL,
                  1'b0, NO_RES);
      end
      frames_done++;
    end
  endtask

  initial begin
    int target;
    int pick;
    int unsigned n;
    width_reg = WIDTH_BITS'(RESET_WIDTH);
    height_reg = HEIGHT_BITS'(RESET_HEIGHT);
    foreach (decided_row[k]) begin
      decided_row[k] = '0;
      raw_row[k] = '0;
    end
    clear_position();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(PLAN); r++) begin
      if (PLAN[r].kind == ROW_REG) begin
        settle();
        write_reg(PLAN[r].idx, PLAN[r].data);
      end else begin
        send_beat(PLAN[r].lbl, PLAN[r].fn, PLAN[r].typed_ok, PLAN[r].typed);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = beats_taken + PHASE_BEATS;
      while (beats_taken < target) begin
        if ($urandom_range(99) < 40) begin
          settle();
          reconfigure();
        end
        n = eff_width() * eff_height();
        pick = $urandom_range(99);
        if (pick < 8) run_frame($urandom_range(n - 1), 1'b1);
        else if (pick < 16) run_frame($urandom_range(n - 1), 1'b0);
        else run_frame(-1, 1'b0);
      end
    end

    // widest row, cut off well inside the first row
    settle();
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0003);
    run_frame(64, 1'b1);
    // tallest frame, started and then abandoned
    write_reg(CFG_IMAGE_WIDTH, 16'h0003);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    run_frame(40, 1'b1);

    settle();
    $display("run covered %0d beats in %0d complete frames and %0d register writes",
             beats_taken, frames_done, reg_writes);
    $display("%0d result beats compared, %0d mismatches", checked, fails);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
